/* hdl/emmb_pkg.sv */
// ----------------------------------------------------------------------------
// emmb_pkg
// Shared types and constants of the Euler model matrix builder.
// ----------------------------------------------------------------------------
package emmb_pkg;

    localparam int CORDIC_ITERS = 30;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [1:0] ROW_POS = 2'd3;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic               opcode;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic               zero_scale_flag;
        logic               last_row;
    } out_t;

    // per-row factor (scale or reciprocal), flags and translation
    typedef struct packed {
        logic             normal;
        logic [2:0][31:0] fac;
        logic [2:0]       zflag;
        logic [2:0][31:0] pos;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] angle_x;
        logic [15:0] angle_y;
        logic [15:0] angle_z;
    } fac_item_t;

    // lane 0: y angle, lane 1: x angle, lane 2: z angle
    typedef struct packed {
        side_t            side;
        logic [2:0][31:0] sin_v;
        logic [2:0][31:0] cos_v;
    } trig_item_t;

    typedef struct packed {
        side_t            side;
        logic [8:0][32:0] rot;
    } rot_item_t;

endpackage

/* hdl/euler_model_matrix_builder.sv */
// ----------------------------------------------------------------------------
// euler_model_matrix_builder
// Builds a scaled YXZ Euler model matrix or a normal matrix per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request: opcode, three binary angles, scale and position.
//   m_* returns the matrix one row per transfer, row_index counting from 0,
//   last_row marking the final row. Opcode 0 gives four rows (rotation rows
//   times scale, then position with 1.0); opcode 1 gives three rows scaled by
//   the reciprocal scale, zero_scale_flag set on a row whose scale was zero.
//   The first row appears after the request passes a 33-stage divider,
//   30-stage CORDIC, 3 rotation-term stages, 2 scaling stages and the
//   output register (at the defaults).
//   The output sends one row per cycle while m_ready is high; a new
//   request is taken only when it is empty or its last row leaves.
//   Reset clears every valid bit; no request is in flight afterwards.
//   When m_ready is low with a row waiting, the whole pipeline holds;
//   s_ready drops with it and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module euler_model_matrix_builder #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  emmb_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output emmb_pkg::out_t  m_data
);
    import emmb_pkg::*;

    logic       adv;
    logic       div_valid, trig_valid, rot_valid;
    fac_item_t  div_data;
    trig_item_t trig_data;
    rot_item_t  rot_data;

    assign s_ready = adv;

    emmb_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    emmb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (trig_valid),
        .out_data  (trig_data)
    );

    emmb_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (trig_valid),
        .in_data   (trig_data),
        .out_valid (rot_valid),
        .out_data  (rot_data)
    );

    emmb_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rot_valid),
        .in_data  (rot_data),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* hdl/emmb_recip.sv */
// ----------------------------------------------------------------------------
// emmb_recip
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Picks the row factor: the scale, or its saturated reciprocal.
// ----------------------------------------------------------------------------
module emmb_recip #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  emmb_pkg::in_t         in_data,
    output logic                  out_valid,
    output emmb_pkg::fac_item_t   out_data
);
    import emmb_pkg::*;

    localparam int QB = 2 * FRAC_BITS + 1;

    typedef struct packed {
        logic [2:0][33:0]   rem;
        logic [2:0][QB-1:0] quo;
        logic [2:0][32:0]   dvs;
        logic [2:0]         neg;
        in_t                item;
    } dst_t;

    dst_t st_reg  [QB];
    logic vld_reg [QB];
    dst_t init;

    always_comb begin
        logic [2:0][31:0] scl;
        logic [32:0]      sx;
        scl = {in_data.scale_z, in_data.scale_y, in_data.scale_x};
        init.item = in_data;
        for (int l = 0; l < 3; l++) begin
            sx = {scl[l][31], scl[l]};
            init.rem[l] = '0;
            init.quo[l] = '0;
            init.neg[l] = scl[l][31];
            init.dvs[l] = scl[l][31] ? (~sx + 33'd1) : sx;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        dst_t cur;
        dst_t nxt;
        logic prev_v;
        if (k == 0) begin : g_first
            assign cur    = init;
            assign prev_v = in_valid;
        end else begin : g_next
            assign cur    = st_reg[k-1];
            assign prev_v = vld_reg[k-1];
        end

        always_comb begin
            logic [33:0] trial;
            logic        qbit;
            nxt = cur;
            for (int l = 0; l < 3; l++) begin
                // the dividend is a single one bit, shifted in on the first step
                trial = {cur.rem[l][32:0], 1'(k == 0)};
                qbit  = (trial >= {1'b0, cur.dvs[l]});
                nxt.rem[l] = qbit ? (trial - {1'b0, cur.dvs[l]}) : trial;
                nxt.quo[l] = {cur.quo[l][QB-2:0], qbit};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= nxt;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];

    always_comb begin
        dst_t             last;
        logic [2:0][31:0] scl;
        logic [63:0]      qz;
        logic [31:0]      r;
        logic             zero;
        last = st_reg[QB-1];
        scl  = {last.item.scale_z, last.item.scale_y, last.item.scale_x};
        out_data.side.normal = last.item.opcode;
        out_data.side.pos    = {last.item.pos_z, last.item.pos_y, last.item.pos_x};
        out_data.angle_x     = last.item.angle_x;
        out_data.angle_y     = last.item.angle_y;
        out_data.angle_z     = last.item.angle_z;
        for (int l = 0; l < 3; l++) begin
            qz   = 64'(last.quo[l]);
            zero = (scl[l] == 32'd0);
            if (!last.neg[l]) begin
                r = (qz > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qz[31:0];
            end else begin
                r = (qz > 64'h8000_0000) ? 32'h8000_0000 : (~qz[31:0] + 32'd1);
            end
            if (last.item.opcode) begin
                out_data.side.fac[l] = zero ? 32'h7FFF_FFFF : r;
            end else begin
                out_data.side.fac[l] = scl[l];
            end
            out_data.side.zflag[l] = last.item.opcode && zero;
        end
    end

endmodule

/* hdl/emmb_cordic.sv */
// ----------------------------------------------------------------------------
// emmb_cordic
// Unrolled rotation-mode CORDIC, one iteration per stage, three angle lanes.
// ----------------------------------------------------------------------------
module emmb_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  emmb_pkg::fac_item_t    in_data,
    output logic                   out_valid,
    output emmb_pkg::trig_item_t   out_data
);
    import emmb_pkg::*;

    localparam int SHIFT = 32 - ANGLE_BITS;

    typedef struct packed {
        logic [2:0][33:0] x;
        logic [2:0][33:0] y;
        logic [2:0][33:0] z;
        logic [2:0]       neg;
        side_t            side;
    } cst_t;

    cst_t st_reg  [CORDIC_ITERS];
    logic vld_reg [CORDIC_ITERS];
    cst_t init;

    always_comb begin
        logic [2:0][15:0] ang;
        logic [31:0]      t;
        logic [31:0]      u;
        ang = {in_data.angle_z, in_data.angle_x, in_data.angle_y};
        init.side = in_data.side;
        for (int l = 0; l < 3; l++) begin
            t = {16'd0, ang[l]} << SHIFT;
            u = t + 32'h4000_0000;
            // fold the left half-turn onto the right one and negate at the end
            if (u[31]) begin
                t = t - 32'h8000_0000;
            end
            init.neg[l] = u[31];
            init.z[l]   = {{2{t[31]}}, t};
            init.x[l]   = CORDIC_GAIN;
            init.y[l]   = '0;
        end
    end

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_stage
        cst_t cur;
        cst_t nxt;
        logic prev_v;
        if (k == 0) begin : g_first
            assign cur    = init;
            assign prev_v = in_valid;
        end else begin : g_next
            assign cur    = st_reg[k-1];
            assign prev_v = vld_reg[k-1];
        end

        always_comb begin
            logic [33:0] xs;
            logic [33:0] ys;
            nxt = cur;
            for (int l = 0; l < 3; l++) begin
                xs = $signed(cur.x[l]) >>> k;
                ys = $signed(cur.y[l]) >>> k;
                if (!cur.z[l][33]) begin
                    nxt.x[l] = cur.x[l] - ys;
                    nxt.y[l] = cur.y[l] + xs;
                    nxt.z[l] = cur.z[l] - {2'b00, ATAN_TURN[k]};
                end else begin
                    nxt.x[l] = cur.x[l] + ys;
                    nxt.y[l] = cur.y[l] - xs;
                    nxt.z[l] = cur.z[l] + {2'b00, ATAN_TURN[k]};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= nxt;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_ITERS-1];

    always_comb begin
        cst_t        last;
        logic [33:0] cv;
        logic [33:0] sv;
        last = st_reg[CORDIC_ITERS-1];
        out_data.side = last.side;
        for (int l = 0; l < 3; l++) begin
            cv = last.neg[l] ? (~last.x[l] + 34'd1) : last.x[l];
            sv = last.neg[l] ? (~last.y[l] + 34'd1) : last.y[l];
            out_data.cos_v[l] = cv[31:0];
            out_data.sin_v[l] = sv[31:0];
        end
    end

endmodule

/* hdl/emmb_rot.sv */
// ----------------------------------------------------------------------------
// emmb_rot
// Forms the nine YXZ rotation terms from the sines and cosines in three
// stages: pair products, triple products, sums.
// ----------------------------------------------------------------------------
module emmb_rot (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  emmb_pkg::trig_item_t   in_data,
    output logic                   out_valid,
    output emmb_pkg::rot_item_t    out_data
);
    import emmb_pkg::*;

    typedef struct packed {
        side_t       side;
        logic [31:0] s2, s3;
        logic [31:0] s1s2, c1s2, c3s1, c1c3, c2s3, c1s3, c2c3, s1s3, c2s1, c1c2;
    } p1_t;

    typedef struct packed {
        side_t       side;
        logic [31:0] s2;
        logic [31:0] q1, q2, q3, q4;
        logic [31:0] c1c3, c2s3, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
    } p2_t;

    p1_t       p1_reg;
    p2_t       p2_reg;
    rot_item_t p3_reg;
    logic      v1_reg, v2_reg, v3_reg;

    function automatic logic [31:0] mul30(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    function automatic logic [32:0] sx(input logic [31:0] a);
        return {a[31], a};
    endfunction

    logic [31:0] s1, c1, s2, c2, s3, c3;
    assign s1 = in_data.sin_v[0];
    assign c1 = in_data.cos_v[0];
    assign s2 = in_data.sin_v[1];
    assign c2 = in_data.cos_v[1];
    assign s3 = in_data.sin_v[2];
    assign c3 = in_data.cos_v[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg.side <= in_data.side;
            p1_reg.s2   <= s2;
            p1_reg.s3   <= s3;
            p1_reg.s1s2 <= mul30(s1, s2);
            p1_reg.c1s2 <= mul30(c1, s2);
            p1_reg.c3s1 <= mul30(c3, s1);
            p1_reg.c1c3 <= mul30(c1, c3);
            p1_reg.c2s3 <= mul30(c2, s3);
            p1_reg.c1s3 <= mul30(c1, s3);
            p1_reg.c2c3 <= mul30(c2, c3);
            p1_reg.s1s3 <= mul30(s1, s3);
            p1_reg.c2s1 <= mul30(c2, s1);
            p1_reg.c1c2 <= mul30(c1, c2);

            p2_reg.side <= p1_reg.side;
            p2_reg.s2   <= p1_reg.s2;
            p2_reg.q1   <= mul30(p1_reg.s1s2, p1_reg.s3);
            p2_reg.q2   <= mul30(p1_reg.c1s2, p1_reg.s3);
            p2_reg.q3   <= mul30(p1_reg.c3s1, p1_reg.s2);
            p2_reg.q4   <= mul30(p1_reg.c1c3, p1_reg.s2);
            p2_reg.c1c3 <= p1_reg.c1c3;
            p2_reg.c2s3 <= p1_reg.c2s3;
            p2_reg.c3s1 <= p1_reg.c3s1;
            p2_reg.c1s3 <= p1_reg.c1s3;
            p2_reg.c2c3 <= p1_reg.c2c3;
            p2_reg.s1s3 <= p1_reg.s1s3;
            p2_reg.c2s1 <= p1_reg.c2s1;
            p2_reg.c1c2 <= p1_reg.c1c2;

            p3_reg.side   <= p2_reg.side;
            p3_reg.rot[0] <= sx(p2_reg.c1c3) + sx(p2_reg.q1);
            p3_reg.rot[1] <= sx(p2_reg.c2s3);
            p3_reg.rot[2] <= sx(p2_reg.q2) - sx(p2_reg.c3s1);
            p3_reg.rot[3] <= sx(p2_reg.q3) - sx(p2_reg.c1s3);
            p3_reg.rot[4] <= sx(p2_reg.c2c3);
            p3_reg.rot[5] <= sx(p2_reg.q4) + sx(p2_reg.s1s3);
            p3_reg.rot[6] <= sx(p2_reg.c2s1);
            p3_reg.rot[7] <= ~sx(p2_reg.s2) + 33'd1;
            p3_reg.rot[8] <= sx(p2_reg.c1c2);
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

endmodule

/* hdl/emmb_rows.sv */
// ----------------------------------------------------------------------------
// emmb_rows
// Scales the rotation terms by the row factors, saturates, and sends the
// matrix out one row per transfer from a held copy of the item.
// ----------------------------------------------------------------------------
module emmb_rows #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  emmb_pkg::rot_item_t   in_data,
    output logic                  adv,
    output logic                  m_valid,
    input  logic                  m_ready,
    output emmb_pkg::out_t        m_data
);
    import emmb_pkg::*;

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    typedef struct packed {
        side_t            side;
        logic [8:0][34:0] e;
    } e1_t;

    typedef struct packed {
        side_t            side;
        logic [8:0][31:0] e;
    } hold_t;

    e1_t   e1_reg, e1_next;
    hold_t e2_reg, e2_next;
    hold_t hold_reg;
    out_t  out_reg;
    logic  v1_reg, v2_reg, out_valid_reg;
    logic  fire;

    always_comb begin
        logic signed [64:0] p;
        e1_next.side = in_data.side;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p = $signed(in_data.side.fac[r]) * $signed(in_data.rot[r*3+c])
                    + 65'sd536870912;
                e1_next.e[r*3+c] = 35'(p >>> 30);
            end
        end
    end

    always_comb begin
        logic signed [34:0] v;
        e2_next.side = e1_reg.side;
        for (int i = 0; i < 9; i++) begin
            v = e1_reg.e[i];
            if (v > 35'sd2147483647) begin
                e2_next.e[i] = 32'h7FFF_FFFF;
            end else if (v < -35'sd2147483648) begin
                e2_next.e[i] = 32'h8000_0000;
            end else begin
                e2_next.e[i] = v[31:0];
            end
        end
    end

    function automatic out_t make_row(input hold_t h, input logic [1:0] idx);
        out_t o;
        o.row_index       = idx;
        o.elem3           = '0;
        o.zero_scale_flag = 1'b0;
        o.last_row        = h.side.normal && (idx == 2'd2);
        case (idx)
            2'd0: begin
                o.elem0           = h.e[0];
                o.elem1           = h.e[1];
                o.elem2           = h.e[2];
                o.zero_scale_flag = h.side.zflag[0];
            end
            2'd1: begin
                o.elem0           = h.e[3];
                o.elem1           = h.e[4];
                o.elem2           = h.e[5];
                o.zero_scale_flag = h.side.zflag[1];
            end
            2'd2: begin
                o.elem0           = h.e[6];
                o.elem1           = h.e[7];
                o.elem2           = h.e[8];
                o.zero_scale_flag = h.side.zflag[2];
            end
            default: begin
                o.elem0    = h.side.pos[0];
                o.elem1    = h.side.pos[1];
                o.elem2    = h.side.pos[2];
                o.elem3    = ONE;
                o.last_row = 1'b1;
            end
        endcase
        return o;
    endfunction

    assign fire    = out_valid_reg && m_ready;
    // take a new item when the output is empty or once the last row of the current one leaves
    assign adv     = !out_valid_reg || (fire && out_reg.last_row);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            if (v2_reg) begin
                hold_reg <= e2_reg;
                out_reg  <= make_row(e2_reg, 2'd0);
            end
        end else if (fire) begin
            out_reg <= make_row(hold_reg, out_reg.row_index + 2'd1);
        end
    end

endmodule

/* hdl/emmb_checker.sv */
// ----------------------------------------------------------------------------
// emmb_checker
// Port-level checks on the row stream of the matrix builder.
// ----------------------------------------------------------------------------
module emmb_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input emmb_pkg::out_t m_data
);
    import emmb_pkg::*;

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("row changed while stalled");

    a_next_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_row |=>
            m_valid && m_data.row_index == $past(m_data.row_index) + 2'd1)
        else $error("matrix rows not contiguous");

    a_pos_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.row_index == ROW_POS |->
            m_data.last_row && m_data.elem3 == ONE && !m_data.zero_scale_flag)
        else $error("bad translation row");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_row |->
            m_data.row_index == 2'd2 || m_data.row_index == ROW_POS)
        else $error("last row at wrong index");

endmodule

bind euler_model_matrix_builder emmb_checker #(.FRAC_BITS(FRAC_BITS)) u_emmb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
